FILE: hdl/mf3_pkg.sv
// Shared types, constants and compare-exchange functions for the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

   // Fixed field widths of the pixel and result transactions.
   localparam int PIX_W   = 8;
   localparam int COORD_W = 10;
   localparam int CSR_W   = 11;

   // Neighborhood size and the position of the median after the network.
   localparam int TAPS    = 9;
   localparam int MID_TAP = 4;

   // Reset value of the image side length register.
   localparam logic [CSR_W-1:0] IMAGE_SIZE_RESET = 11'd1024;

   typedef logic [PIX_W-1:0]     pix_type;
   typedef pix_type [TAPS-1:0]   win_type;
   typedef logic [3:0]           tap_idx_type;
   typedef logic [3:0]           slot_type;

   // One-hot result slots of one input transaction, emitted lowest first.
   localparam slot_type SLOT_MAIN   = 4'b0001;  // pixel up and to the left
   localparam slot_type SLOT_RIGHT  = 4'b0010;  // right border pixel of the previous row
   localparam slot_type SLOT_BOTTOM = 4'b0100;  // bottom border pixel, one column back
   localparam slot_type SLOT_CORNER = 4'b1000;  // bottom right corner pixel

   // Order two taps so that the smaller one sits at index a.
   function automatic win_type cmp_xchg(win_type v, tap_idx_type a, tap_idx_type b);
      win_type r;
      r = v;
      if (v[a] > v[b]) begin
         r[a] = v[b];
         r[b] = v[a];
      end
      return r;
   endfunction

   // First half of the median network: sort each group of three taps.
   function automatic win_type sort_columns(win_type v);
      win_type w;
      w = v;
      w = cmp_xchg(w, 4'd1, 4'd2);
      w = cmp_xchg(w, 4'd4, 4'd5);
      w = cmp_xchg(w, 4'd7, 4'd8);
      w = cmp_xchg(w, 4'd0, 4'd1);
      w = cmp_xchg(w, 4'd3, 4'd4);
      w = cmp_xchg(w, 4'd6, 4'd7);
      w = cmp_xchg(w, 4'd1, 4'd2);
      w = cmp_xchg(w, 4'd4, 4'd5);
      w = cmp_xchg(w, 4'd7, 4'd8);
      return w;
   endfunction

   // Second half of the median network: merge the sorted groups, pick the middle.
   function automatic pix_type median_merge(win_type v);
      win_type w;
      w = v;
      w = cmp_xchg(w, 4'd0, 4'd3);
      w = cmp_xchg(w, 4'd5, 4'd8);
      w = cmp_xchg(w, 4'd4, 4'd7);
      w = cmp_xchg(w, 4'd3, 4'd6);
      w = cmp_xchg(w, 4'd1, 4'd4);
      w = cmp_xchg(w, 4'd2, 4'd5);
      w = cmp_xchg(w, 4'd4, 4'd7);
      w = cmp_xchg(w, 4'd4, 4'd2);
      w = cmp_xchg(w, 4'd6, 4'd4);
      w = cmp_xchg(w, 4'd4, 4'd2);
      return w[MID_TAP];
   endfunction

endpackage

FILE: hdl/mf3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/median_filter_3x3.sv
// 3x3 median filter over a square 8-bit grayscale raster stream.
`timescale 1ns / 1ps

// The block takes one pixel per clock in raster order unless stalled, and
// keeps the two previous rows in a line store RAM and the two previous
// columns in a window register. Interior pixels leave as the median of their
// 3x3 neighborhood; border pixels pass through unchanged. Results lag by one
// row and one column and carry their row and column, and run_last marks the
// final result caused by each input transaction. An accepted pixel passes
// stage 1, stage 2 and the result group register before its first result.
// An input causes up to four results and the result port moves one per clock
// while rsp_stall is low. Row 0 causes no results. In the other rows one pixel
// is accepted every clock while rsp_stall is low, because the second result
// at the end of a row fills the empty slot left by the column-0 pixel that
// follows it. In the last row each pixel from column 1 on causes two results
// and the corner pixel four, so there the input is stalled while the extra
// results leave. Writing the image size restarts the frame at row 0, column 0.
module median_filter_3x3
   import mf3_pkg::*;
#(
   parameter int MAX_SIZE = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // Pixel input channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIX_W-1:0]   req_pixel_in,
   // Result channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIX_W-1:0]   rsp_pixel_out,
   output logic [COORD_W-1:0] rsp_out_row,
   output logic [COORD_W-1:0] rsp_out_col,
   output logic               rsp_run_last,
   // Image size register.
   input  logic               csr_write_en,
   input  logic [CSR_W-1:0]   csr_image_size
);

   localparam int CW = $clog2(MAX_SIZE);

   // Configuration and position state.
   logic [CSR_W-1:0] image_size_ff, image_size_in;
   logic [CW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   pix_type          win_ff [6];
   pix_type          win_in [6];

   // Pipeline stage 1: raw neighborhood.
   logic             s1_valid_ff, s1_valid_in;
   slot_type         s1_mask_ff, s1_mask_in;
   logic             s1_med_ff, s1_med_in;
   win_type          s1_taps_ff, s1_taps_in;
   logic [CW-1:0]    s1_row_ff, s1_row_in;
   logic [CW-1:0]    s1_col_ff, s1_col_in;

   // Pipeline stage 2: columns sorted, border values kept aside.
   logic             s2_valid_ff, s2_valid_in;
   slot_type         s2_mask_ff, s2_mask_in;
   logic             s2_med_ff, s2_med_in;
   win_type          s2_taps_ff, s2_taps_in;
   pix_type          s2_pass_ff [4];
   pix_type          s2_pass_in [4];
   logic [CW-1:0]    s2_row_ff, s2_row_in;
   logic [CW-1:0]    s2_col_ff, s2_col_in;

   // Result group: all results of one input transaction.
   logic             grp_valid_ff, grp_valid_in;
   slot_type         grp_mask_ff, grp_mask_in;
   pix_type          grp_val_ff [4];
   pix_type          grp_val_in [4];
   logic [CW-1:0]    grp_row_ff, grp_row_in;
   logic [CW-1:0]    grp_col_ff, grp_col_in;

   // Combinational helpers.
   logic [CW+11:0]   size_wide;
   logic [CW:0]      side;
   logic [CW:0]      side_m1;
   logic [CW-1:0]    last_idx;
   logic             req_accept;
   logic             rsp_accept;
   logic             grp_take;
   logic             s2_ready;
   logic             s1_ready;
   slot_type         grp_onehot;
   slot_type         grp_rest;
   slot_type         emit_mask;
   pix_type          up_pix;
   pix_type          lo_pix;
   logic [2*PIX_W-1:0] ls_rd_data;
   logic [CW-1:0]    ls_rd_addr;
   pix_type          sel_val;
   logic [CW-1:0]    sel_row;
   logic [CW-1:0]    sel_col;
   logic [CW+9:0]    row_wide;
   logic [CW+9:0]    col_wide;

   // Effective side length: register value saturated to 3..MAX_SIZE.
   always_comb begin
      size_wide = {{(CW+1){1'b0}}, image_size_ff};
      if (size_wide < (CW+12)'(3)) begin
         side = (CW+1)'(3);
      end else if (size_wide > (CW+12)'(MAX_SIZE)) begin
         side = (CW+1)'(MAX_SIZE);
      end else begin
         side = size_wide[CW:0];
      end
      side_m1  = side - 1'b1;
      last_idx = side_m1[CW-1:0];
   end

   // Handshake and pipeline advance.
   always_comb begin
      grp_onehot = grp_mask_ff & (~grp_mask_ff + 4'd1);
      grp_rest   = grp_mask_ff & ~grp_onehot;
      rsp_accept = grp_valid_ff & ~rsp_stall;
      grp_take   = ~grp_valid_ff | (rsp_accept & (grp_rest == '0));
      s2_ready   = ~s2_valid_ff | grp_take;
      s1_ready   = ~s1_valid_ff | s2_ready;
      req_accept = req_valid & s1_ready;
   end

   assign req_stall = ~s1_ready;

   // Line store holds {row r-2, row r-1} for every column.
   assign up_pix     = ls_rd_data[2*PIX_W-1:PIX_W];
   assign lo_pix     = ls_rd_data[PIX_W-1:0];
   assign ls_rd_addr = reset ? '0 : col_in;

   mf3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_SIZE)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col_ff),
      .wr_data ({lo_pix, req_pixel_in}),
      .rd_addr (ls_rd_addr),
      .rd_data (ls_rd_data)
   );

   // Position counters, window shift and the image size register.
   always_comb begin
      image_size_in = image_size_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      if (csr_write_en) begin
         image_size_in = csr_image_size;
         row_in        = '0;
         col_in        = '0;
      end else if (req_accept) begin
         if (col_ff == last_idx) begin
            col_in = '0;
            row_in = (row_ff == last_idx) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (req_accept) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = up_pix;
         win_in[4] = lo_pix;
         win_in[5] = req_pixel_in;
      end
   end

   // Which results this pixel causes, and its neighborhood.
   always_comb begin
      emit_mask[0] = (row_ff != '0) && (col_ff != '0);
      emit_mask[1] = (row_ff != '0) && (col_ff == last_idx);
      emit_mask[2] = (row_ff == last_idx) && (col_ff != '0);
      emit_mask[3] = (row_ff == last_idx) && (col_ff == last_idx);
      s1_mask_in   = emit_mask;
      s1_med_in    = (row_ff >= CW'(2)) && (col_ff >= CW'(2));
      s1_taps_in[0] = win_ff[0];
      s1_taps_in[1] = win_ff[3];
      s1_taps_in[2] = up_pix;
      s1_taps_in[3] = win_ff[1];
      s1_taps_in[4] = win_ff[4];
      s1_taps_in[5] = lo_pix;
      s1_taps_in[6] = win_ff[2];
      s1_taps_in[7] = win_ff[5];
      s1_taps_in[8] = req_pixel_in;
      s1_row_in     = row_ff;
      s1_col_in     = col_ff;
      s1_valid_in   = s1_ready ? (req_accept & (emit_mask != '0)) : s1_valid_ff;
   end

   // Stage 2: first half of the median network.
   always_comb begin
      s2_valid_in   = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_mask_in    = s1_mask_ff;
      s2_med_in     = s1_med_ff;
      s2_taps_in    = sort_columns(s1_taps_ff);
      s2_pass_in[0] = s1_taps_ff[4];
      s2_pass_in[1] = s1_taps_ff[5];
      s2_pass_in[2] = s1_taps_ff[7];
      s2_pass_in[3] = s1_taps_ff[8];
      s2_row_in     = s1_row_ff;
      s2_col_in     = s1_col_ff;
   end

   // Result group: finish the median, then hand out its results one at a time, lowest slot first.
   always_comb begin
      grp_valid_in  = grp_valid_ff;
      grp_mask_in   = grp_mask_ff;
      grp_val_in[0] = s2_med_ff ? median_merge(s2_taps_ff) : s2_pass_ff[0];
      grp_val_in[1] = s2_pass_ff[1];
      grp_val_in[2] = s2_pass_ff[2];
      grp_val_in[3] = s2_pass_ff[3];
      grp_row_in    = s2_row_ff;
      grp_col_in    = s2_col_ff;
      if (grp_take) begin
         grp_valid_in = s2_valid_ff;
         grp_mask_in  = s2_mask_ff;
      end else if (rsp_accept) begin
         grp_mask_in  = grp_rest;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= IMAGE_SIZE_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         grp_valid_ff  <= 1'b0;
         grp_mask_ff   <= '0;
      end else begin
         image_size_ff <= image_size_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         grp_valid_ff  <= grp_valid_in;
         grp_mask_ff   <= grp_mask_in;
      end
   end

   // Payload registers, loaded as each stage advances.
   always_ff @(posedge clock) begin
      if (s1_ready && req_accept) begin
         s1_mask_ff <= s1_mask_in;
         s1_med_ff  <= s1_med_in;
         s1_taps_ff <= s1_taps_in;
         s1_row_ff  <= s1_row_in;
         s1_col_ff  <= s1_col_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_mask_ff <= s2_mask_in;
         s2_med_ff  <= s2_med_in;
         s2_taps_ff <= s2_taps_in;
         for (int i = 0; i < 4; i++) begin
            s2_pass_ff[i] <= s2_pass_in[i];
         end
         s2_row_ff  <= s2_row_in;
         s2_col_ff  <= s2_col_in;
      end
      if (grp_take && s2_valid_ff) begin
         for (int i = 0; i < 4; i++) begin
            grp_val_ff[i] <= grp_val_in[i];
         end
         grp_row_ff <= grp_row_in;
         grp_col_ff <= grp_col_in;
      end
   end

   // Output select for the lowest pending slot.
   always_comb begin
      case (grp_onehot)
         SLOT_MAIN: begin
            sel_val = grp_val_ff[0];
            sel_row = grp_row_ff - 1'b1;
            sel_col = grp_col_ff - 1'b1;
         end
         SLOT_RIGHT: begin
            sel_val = grp_val_ff[1];
            sel_row = grp_row_ff - 1'b1;
            sel_col = grp_col_ff;
         end
         SLOT_BOTTOM: begin
            sel_val = grp_val_ff[2];
            sel_row = grp_row_ff;
            sel_col = grp_col_ff - 1'b1;
         end
         SLOT_CORNER: begin
            sel_val = grp_val_ff[3];
            sel_row = grp_row_ff;
            sel_col = grp_col_ff;
         end
         default: begin
            sel_val = grp_val_ff[0];
            sel_row = grp_row_ff - 1'b1;
            sel_col = grp_col_ff - 1'b1;
         end
      endcase
      row_wide = {10'b0, sel_row};
      col_wide = {10'b0, sel_col};
   end

   assign rsp_valid     = grp_valid_ff;
   assign rsp_pixel_out = sel_val;
   assign rsp_out_row   = row_wide[COORD_W-1:0];
   assign rsp_out_col   = col_wide[COORD_W-1:0];
   assign rsp_run_last  = (grp_rest == '0);

endmodule
